[rtl/core/plate_corner_decode_assert.svh]
// Assertion macros used by the checker file
`ifndef PLATE_CORNER_DECODE_ASSERT_SVH
`define PLATE_CORNER_DECODE_ASSERT_SVH

// Implication in the same cycle
`define PCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles
`define PCD_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

[rtl/core/pcd_pkg.sv]
`timescale 1ns / 1ps
package pcd_pkg;

	localparam int DimW    = 13;
	localparam int CfgW    = 16;
	localparam int CoordW  = 18;
	localparam int ScoreW  = 16;
	localparam int OffW    = 16;
	localparam int HalfW   = 16;

	localparam logic [DimW-1:0]   ImageWidthRst     = 13'd640;
	localparam logic [DimW-1:0]   ImageHeightRst    = 13'd640;
	localparam logic [ScoreW-1:0] ScoreThresholdRst = 16'd16384;
	localparam logic [CfgW-1:0]   OffsetScaleRst    = 16'd6554;

	localparam logic signed [CoordW-1:0] CoordMax = 18'sh1FFFF;
	localparam logic signed [CoordW-1:0] CoordMin = 18'sh20000;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH     = 2'd0,
		CFG_IMAGE_HEIGHT    = 2'd1,
		CFG_SCORE_THRESHOLD = 2'd2,
		CFG_OFFSET_SCALE    = 2'd3
	} cfg_idx_t;

	// load enables of the five pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pcd_adv_t;

endpackage

[rtl/core/pcd_coord_lane.sv]
`timescale 1ns / 1ps
module pcd_coord_lane (
	input  logic                                 clk,
	input  pcd_pkg::pcd_adv_t                    adv,
	input  logic signed [pcd_pkg::OffW-1:0]      offset,
	input  logic        [pcd_pkg::HalfW-1:0]     centre,
	input  logic        [pcd_pkg::HalfW-1:0]     size,
	input  logic        [pcd_pkg::CfgW-1:0]      scale,
	input  logic        [pcd_pkg::DimW-1:0]      dim,
	output logic signed [pcd_pkg::CoordW-1:0]    coord
);
	import pcd_pkg::*;

	logic signed [32:0]       t_s1;
	logic        [HalfW-1:0]  size_s1;
	logic        [HalfW-1:0]  centre_s1;
	logic signed [49:0]       u_s2;
	logic        [HalfW-1:0]  centre_s2;
	logic signed [50:0]       sum_s3;
	logic signed [64:0]       prod_s4;
	logic signed [25:0]       pix;
	logic signed [CoordW-1:0] coord_s5;

	function automatic logic signed [CoordW-1:0] coord_sat(logic signed [25:0] v);
		logic signed [CoordW-1:0] r;
		if (v[25:CoordW-1] == '0 || v[25:CoordW-1] == '1) begin
			r = v[CoordW-1:0];
		end else if (v[25]) begin
			r = CoordMin;
		end else begin
			r = CoordMax;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			t_s1      <= $signed(offset) * $signed({1'b0, scale});
			size_s1   <= size;
			centre_s1 <= centre;
		end
		if (adv.s2) begin
			u_s2      <= t_s1 * $signed({1'b0, size_s1});
			centre_s2 <= centre_s1;
		end
		if (adv.s3) begin
			sum_s3 <= $signed({7'd0, centre_s2, 28'd0}) + u_s2;
		end
		if (adv.s4) begin
			prod_s4 <= sum_s3 * $signed({1'b0, dim});
		end
		if (adv.s5) begin
			coord_s5 <= coord_sat(pix);
		end
	end

	// arithmetic shift by 39 is the floor toward minus infinity
	assign pix = $signed(prod_s4[64:39]);

	assign coord = coord_s5;

endmodule

[rtl/core/pcd_score.sv]
`timescale 1ns / 1ps
module pcd_score (
	input  logic                             clk,
	input  pcd_pkg::pcd_adv_t                adv,
	input  logic        [pcd_pkg::ScoreW-1:0] confidence,
	input  logic signed [pcd_pkg::ScoreW-1:0] overlap,
	input  logic        [pcd_pkg::ScoreW-1:0] threshold,
	output logic        [pcd_pkg::ScoreW-1:0] score,
	output logic                             keep
);
	import pcd_pkg::*;

	typedef struct packed {
		logic [17:0]       rem;
		logic [ScoreW-1:0] root;
	} sq_t;

	logic [ScoreW-1:0] ov_clamp;
	logic [31:0]       prod_s1;
	logic [23:0]       bits_s2;
	logic [15:0]       bits_s3;
	logic [7:0]        bits_s4;
	sq_t               sq_s2;
	sq_t               sq_s3;
	sq_t               sq_s4;
	sq_t               sq_last;
	logic [ScoreW-1:0] score_s5;
	logic              keep_s5;

	// four result bits per stage, two radicand bits each
	function automatic sq_t sq_step4(sq_t in, logic [7:0] pairs);
		sq_t         cur;
		logic [19:0] rem_w;
		logic [19:0] trial;
		cur = in;
		for (int i = 3; i >= 0; i--) begin
			rem_w = {cur.rem, pairs[2*i+1 -: 2]};
			trial = {2'b00, cur.root, 2'b01};
			if (rem_w >= trial) begin
				cur.rem  = 18'(rem_w - trial);
				cur.root = {cur.root[ScoreW-2:0], 1'b1};
			end else begin
				cur.rem  = rem_w[17:0];
				cur.root = {cur.root[ScoreW-2:0], 1'b0};
			end
		end
		return cur;
	endfunction

	// negative overlap clamps to zero; above one cannot be coded
	assign ov_clamp = overlap[ScoreW-1] ? '0 : overlap;

	assign sq_last = sq_step4(sq_s4, bits_s4);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_s1 <= confidence * ov_clamp;
		end
		if (adv.s2) begin
			sq_s2   <= sq_step4('0, prod_s1[31:24]);
			bits_s2 <= prod_s1[23:0];
		end
		if (adv.s3) begin
			sq_s3   <= sq_step4(sq_s2, bits_s2[23:16]);
			bits_s3 <= bits_s2[15:0];
		end
		if (adv.s4) begin
			sq_s4   <= sq_step4(sq_s3, bits_s3[15:8]);
			bits_s4 <= bits_s3[7:0];
		end
		if (adv.s5) begin
			score_s5 <= sq_last.root;
			keep_s5  <= sq_last.root > threshold;
		end
	end

	assign score = score_s5;
	assign keep  = keep_s5;

endmodule

[rtl/core/plate_corner_decode.sv]
`timescale 1ns / 1ps
// Prior box decoder: four corner points and a detection score per prior.
// Command channel: an item is taken at a rising edge with start high and
// busy low. busy is always low, so one item can be taken every cycle.
// Result channel: done is high for one cycle with the corner coordinates,
// detection_score and keep; the receiver takes the result in that cycle
// and cannot hold it off.
// Pipeline: an item taken at start moves through stages s1 to s5, and done is
// the registered valid bit of s5; the five-stage pipeline holds up to five
// items in flight.
// Throughput: one item per cycle. The longest stage is the 51 x 14 bit
// coordinate multiply by the image dimension; the score square root
// resolves four result bits in each of four stages.
// Configuration: write transactions on cfg_valid/cfg_ready (ready always
// high) set image_width, image_height, score_threshold and offset_scale by
// cfg_index; write them only while no item is in flight.
// Reset: arst_n clears the pipeline valid bits and loads the registers
// with 640, 640, 16384 and 6554; no clearing pass follows.
module plate_corner_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  pcd_pkg::cfg_idx_t             cfg_index,
	input  logic [pcd_pkg::CfgW-1:0]      cfg_data,
	input  logic [31:0]                   prior_center,
	input  logic [31:0]                   prior_size,
	input  logic signed [15:0]            corner_a_dx,
	input  logic signed [15:0]            corner_a_dy,
	input  logic signed [15:0]            corner_b_dx,
	input  logic signed [15:0]            corner_b_dy,
	input  logic signed [15:0]            corner_c_dx,
	input  logic signed [15:0]            corner_c_dy,
	input  logic signed [15:0]            corner_d_dx,
	input  logic signed [15:0]            corner_d_dy,
	input  logic [15:0]                   plate_confidence,
	input  logic signed [15:0]            overlap_quality,
	output logic signed [17:0]            corner_a_x,
	output logic signed [17:0]            corner_a_y,
	output logic signed [17:0]            corner_b_x,
	output logic signed [17:0]            corner_b_y,
	output logic signed [17:0]            corner_c_x,
	output logic signed [17:0]            corner_c_y,
	output logic signed [17:0]            corner_d_x,
	output logic signed [17:0]            corner_d_y,
	output logic [15:0]                   detection_score,
	output logic                          keep
);
	import pcd_pkg::*;

	logic [DimW-1:0]   image_width_q;
	logic [DimW-1:0]   image_height_q;
	logic [ScoreW-1:0] score_threshold_q;
	logic [CfgW-1:0]   offset_scale_q;
	logic              accept;
	logic              cfg_we;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic              v_s4;
	logic              v_s5;
	pcd_adv_t          adv;
	logic [HalfW-1:0]  cx;
	logic [HalfW-1:0]  cy;
	logic [HalfW-1:0]  sx;
	logic [HalfW-1:0]  sy;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= ImageWidthRst;
			image_height_q    <= ImageHeightRst;
			score_threshold_q <= ScoreThresholdRst;
			offset_scale_q    <= OffsetScaleRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:     image_width_q     <= cfg_data[DimW-1:0];
				CFG_IMAGE_HEIGHT:    image_height_q    <= cfg_data[DimW-1:0];
				CFG_SCORE_THRESHOLD: score_threshold_q <= cfg_data;
				CFG_OFFSET_SCALE:    offset_scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign adv.s1 = accept;
	assign adv.s2 = v_s1;
	assign adv.s3 = v_s2;
	assign adv.s4 = v_s3;
	assign adv.s5 = v_s4;

	assign done = v_s5;

	assign cx = prior_center[15:0];
	assign cy = prior_center[31:16];
	assign sx = prior_size[15:0];
	assign sy = prior_size[31:16];

	pcd_coord_lane u_a_x (.clk(clk), .adv(adv), .offset(corner_a_dx), .centre(cx), .size(sx),
		.scale(offset_scale_q), .dim(image_width_q), .coord(corner_a_x));
	pcd_coord_lane u_a_y (.clk(clk), .adv(adv), .offset(corner_a_dy), .centre(cy), .size(sy),
		.scale(offset_scale_q), .dim(image_height_q), .coord(corner_a_y));
	pcd_coord_lane u_b_x (.clk(clk), .adv(adv), .offset(corner_b_dx), .centre(cx), .size(sx),
		.scale(offset_scale_q), .dim(image_width_q), .coord(corner_b_x));
	pcd_coord_lane u_b_y (.clk(clk), .adv(adv), .offset(corner_b_dy), .centre(cy), .size(sy),
		.scale(offset_scale_q), .dim(image_height_q), .coord(corner_b_y));
	pcd_coord_lane u_c_x (.clk(clk), .adv(adv), .offset(corner_c_dx), .centre(cx), .size(sx),
		.scale(offset_scale_q), .dim(image_width_q), .coord(corner_c_x));
	pcd_coord_lane u_c_y (.clk(clk), .adv(adv), .offset(corner_c_dy), .centre(cy), .size(sy),
		.scale(offset_scale_q), .dim(image_height_q), .coord(corner_c_y));
	pcd_coord_lane u_d_x (.clk(clk), .adv(adv), .offset(corner_d_dx), .centre(cx), .size(sx),
		.scale(offset_scale_q), .dim(image_width_q), .coord(corner_d_x));
	pcd_coord_lane u_d_y (.clk(clk), .adv(adv), .offset(corner_d_dy), .centre(cy), .size(sy),
		.scale(offset_scale_q), .dim(image_height_q), .coord(corner_d_y));

	pcd_score u_score (
		.clk        (clk),
		.adv        (adv),
		.confidence (plate_confidence),
		.overlap    (overlap_quality),
		.threshold  (score_threshold_q),
		.score      (detection_score),
		.keep       (keep)
	);

endmodule

[rtl/core/pcd_checker.sv]
`timescale 1ns / 1ps
`include "plate_corner_decode_assert.svh"
module pcd_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      done,
	input  logic [15:0]               detection_score,
	input  logic                      keep
);

	`PCD_ASSERT_DELAY(a_latency, start && !busy, 5, done, "transaction result missing")
	`PCD_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 5), "result without transaction")
	`PCD_ASSERT_IMP(a_keep_score, done && keep, detection_score != 16'd0, "keep with zero score")
	`PCD_ASSERT_IMP(a_score_max, done, detection_score <= 16'd46340, "score above root bound")

endmodule

bind plate_corner_decode pcd_checker u_pcd_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import pcd_pkg::*;

	typedef struct packed {
		logic [31:0]       center;
		logic [31:0]       size;
		logic [7:0][15:0]  off;
		logic [15:0]       conf;
		logic [15:0]       overlap;
	} prior_t;

	typedef struct packed {
		logic [7:0][17:0] corner;
		logic [15:0]      score;
		logic             keep;
	} detection_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              done;
	logic              cfg_valid;
	logic              cfg_ready;
	cfg_idx_t          cfg_index;
	logic [CfgW-1:0]   cfg_data;
	logic [31:0]       prior_center;
	logic [31:0]       prior_size;
	logic signed [15:0] corner_a_dx, corner_a_dy, corner_b_dx, corner_b_dy;
	logic signed [15:0] corner_c_dx, corner_c_dy, corner_d_dx, corner_d_dy;
	logic [15:0]       plate_confidence;
	logic signed [15:0] overlap_quality;
	logic signed [17:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;
	logic signed [17:0] corner_c_x, corner_c_y, corner_d_x, corner_d_y;
	logic [15:0]       detection_score;
	logic              keep;

	logic [DimW-1:0]   width_reg     = ImageWidthRst;
	logic [DimW-1:0]   height_reg    = ImageHeightRst;
	logic [ScoreW-1:0] threshold_reg = ScoreThresholdRst;
	logic [CfgW-1:0]   scale_reg     = OffsetScaleRst;

	detection_t detections_due[$];
	int         mismatches = 0;
	int         burst_left = 0;
	bit         allow_gaps = 1'b1;

	string corner_names[8] = '{"corner_a_x", "corner_a_y", "corner_b_x", "corner_b_y",
		"corner_c_x", "corner_c_y", "corner_d_x", "corner_d_y"};

	plate_corner_decode dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .prior_center(prior_center), .prior_size(prior_size),
		.corner_a_dx(corner_a_dx), .corner_a_dy(corner_a_dy),
		.corner_b_dx(corner_b_dx), .corner_b_dy(corner_b_dy),
		.corner_c_dx(corner_c_dx), .corner_c_dy(corner_c_dy),
		.corner_d_dx(corner_d_dx), .corner_d_dy(corner_d_dy),
		.plate_confidence(plate_confidence), .overlap_quality(overlap_quality),
		.corner_a_x(corner_a_x), .corner_a_y(corner_a_y),
		.corner_b_x(corner_b_x), .corner_b_y(corner_b_y),
		.corner_c_x(corner_c_x), .corner_c_y(corner_c_y),
		.corner_d_x(corner_d_x), .corner_d_y(corner_d_y),
		.detection_score(detection_score), .keep(keep)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [17:0] corner_coord(input logic [15:0] centre,
		input logic [15:0] extent, input logic signed [15:0] off,
		input logic [DimW-1:0] dim, input logic [CfgW-1:0] scale);
		longint acc;
		longint pix;
		acc = (longint'(centre) <<< 28) + longint'(off) * longint'(scale) * longint'(extent);
		pix = (acc * longint'(dim)) >>> 39;
		if (pix > CoordMax)
			pix = CoordMax;
		else if (pix < CoordMin)
			pix = CoordMin;
		return pix[17:0];
	endfunction

	function automatic logic [15:0] root_score(input logic [15:0] conf,
		input logic signed [15:0] ov);
		longint radicand;
		longint trial;
		logic [15:0] root;
		radicand = (ov < 0) ? 0 : longint'(ov);
		if (radicand > 32768)
			radicand = 32768;
		radicand = radicand * longint'(conf);
		root = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = longint'(root | (16'd1 << b));
			if (trial * trial <= radicand)
				root[b] = 1'b1;
		end
		return root;
	endfunction

	function automatic detection_t decode_prior(input prior_t p);
		detection_t d;
		for (int k = 0; k < 4; k++) begin
			d.corner[2*k] = corner_coord(p.center[15:0], p.size[15:0], p.off[2*k],
				width_reg, scale_reg);
			d.corner[2*k+1] = corner_coord(p.center[31:16], p.size[31:16], p.off[2*k+1],
				height_reg, scale_reg);
		end
		d.score = root_score(p.conf, p.overlap);
		d.keep  = d.score > threshold_reg;
		return d;
	endfunction

	task automatic compare_detection(input detection_t want, input detection_t got);
		for (int k = 0; k < 8; k++)
			if (got.corner[k] !== want.corner[k]) begin
				$error("%s: expected %0d, got %0d", corner_names[k],
					$signed(want.corner[k]), $signed(got.corner[k]));
				mismatches++;
			end
		if (got.score !== want.score) begin
			$error("detection_score: expected %0d, got %0d", want.score, got.score);
			mismatches++;
		end
		if (got.keep !== want.keep) begin
			$error("keep: expected %0d, got %0d", want.keep, got.keep);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : monitor
		detection_t got;
		prior_t     taken;
		if (arst_n) begin
			if (done) begin
				got.corner = {corner_d_y, corner_d_x, corner_c_y, corner_c_x,
					corner_b_y, corner_b_x, corner_a_y, corner_a_x};
				got.score = detection_score;
				got.keep  = keep;
				if (detections_due.size() == 0) begin
					$error("unexpected result transaction");
					mismatches++;
				end else
					compare_detection(detections_due.pop_front(), got);
			end
			if (start && !busy) begin
				taken.center  = prior_center;
				taken.size    = prior_size;
				taken.off     = {corner_d_dy, corner_d_dx, corner_c_dy, corner_c_dx,
					corner_b_dy, corner_b_dx, corner_a_dy, corner_a_dx};
				taken.conf    = plate_confidence;
				taken.overlap = overlap_quality;
				detections_due.insert(detections_due.size(), decode_prior(taken));
			end
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					CFG_IMAGE_WIDTH:     width_reg     = cfg_data[DimW-1:0];
					CFG_IMAGE_HEIGHT:    height_reg    = cfg_data[DimW-1:0];
					CFG_SCORE_THRESHOLD: threshold_reg = cfg_data;
					CFG_OFFSET_SCALE:    scale_reg     = cfg_data;
					default: ;
				endcase
		end
	end

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic pace();
		if (!allow_gaps)
			return;
		if (burst_left == 0) begin
			idle_cycles($urandom_range(1, 6));
			burst_left = $urandom_range(0, 24);
		end else
			burst_left--;
	endtask

	task automatic send_prior(input prior_t p);
		prior_center     <= p.center;
		prior_size       <= p.size;
		corner_a_dx      <= p.off[0];
		corner_a_dy      <= p.off[1];
		corner_b_dx      <= p.off[2];
		corner_b_dy      <= p.off[3];
		corner_c_dx      <= p.off[4];
		corner_c_dy      <= p.off[5];
		corner_d_dx      <= p.off[6];
		corner_d_dy      <= p.off[7];
		plate_confidence <= p.conf;
		overlap_quality  <= p.overlap;
		start            <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pace();
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		idle_cycles(1);
		while (detections_due.size() != 0 && waited < 64) begin
			@(posedge clk);
			waited++;
		end
		if (detections_due.size() != 0) begin
			$error("%0d result transactions missing", detections_due.size());
			mismatches++;
			detections_due.delete();
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [15:0] w, input logic [15:0] h,
		input logic [15:0] thr, input logic [15:0] scale);
		drain();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_SCORE_THRESHOLD, thr);
		write_reg(CFG_OFFSET_SCALE, scale);
	endtask

	function automatic prior_t make_prior(input logic [31:0] center, input logic [31:0] size,
		input logic [15:0] off, input logic [15:0] conf, input logic [15:0] ov);
		prior_t p;
		p.center = center;
		p.size   = size;
		for (int k = 0; k < 8; k++)
			p.off[k] = k[0] ? ~off : off;
		p.conf    = conf;
		p.overlap = ov;
		return p;
	endfunction

	function automatic prior_t random_prior();
		prior_t p;
		int     tmp;
		if ($urandom_range(0, 9) < 7) begin
			p.center = {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768))};
			p.size   = {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768))};
			for (int k = 0; k < 8; k++) begin
				tmp = int'($urandom_range(0, 8192)) - 4096;
				p.off[k] = tmp[15:0];
			end
			p.conf = 16'($urandom_range(0, 32768));
			tmp = int'($urandom_range(0, 36000)) - 3000;
			p.overlap = tmp[15:0];
		end else begin
			p.center = $urandom;
			p.size   = $urandom;
			for (int k = 0; k < 8; k++)
				p.off[k] = 16'($urandom);
			p.conf    = 16'($urandom);
			p.overlap = 16'($urandom);
		end
		return p;
	endfunction

	task automatic test_reset_defaults();
		send_prior(make_prior(32'h4000_4000, 32'h2000_2000, 16'h1000, 16'd16384, 16'd16384));
		send_prior(make_prior(32'h4000_4000, 32'h2000_2000, 16'h0800, 16'd16385, 16'd16385));
		send_prior(make_prior(32'h1234_5678, 32'h0800_0400, 16'h0000, 16'd32768, 16'h8000));
		send_prior(make_prior(32'h6000_2000, 32'h1000_3000, 16'hF000, 16'd20000, 16'hFFFF));
		send_prior(make_prior(32'h8000_8000, 32'h8000_8000, 16'h2000, 16'hFFFF, 16'h7FFF));
		send_prior(make_prior(32'h0000_0000, 32'h0000_0000, 16'h0001, 16'd32768, 16'h0001));
	endtask

	task automatic test_field_extremes();
		apply_config(16'd4096, 16'd4096, 16'd0, 16'hFFFF);
		send_prior(make_prior(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000));
		send_prior(make_prior(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF));
		send_prior(make_prior(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000));
		send_prior(make_prior(32'hAAAA_5555, 32'h5555_AAAA, 16'hAAAA, 16'h5555, 16'h5555));
		send_prior(make_prior(32'h5555_AAAA, 32'hAAAA_5555, 16'h5555, 16'hAAAA, 16'h2AAA));
	endtask

	task automatic test_config_extremes();
		logic [15:0] settings [5][4];
		settings = '{
			'{16'd1, 16'd4096, 16'd0, 16'd0},
			'{16'd4096, 16'd1, 16'd32768, 16'hFFFF},
			'{16'd0, 16'd640, 16'hFFFF, 16'd6554},
			'{16'hFFFF, 16'h2000, 16'd16384, 16'd1},
			'{16'd4096, 16'd4096, 16'd32767, 16'hFFFF}};
		for (int s = 0; s < 5; s++) begin
			apply_config(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
			send_prior(make_prior(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'd32768,
				16'h7FFF));
			send_prior(make_prior(32'h0000_0001, 32'hFFFF_FFFF, 16'h8000, 16'd32767,
				16'd32767));
			repeat (4) send_prior(random_prior());
		end
	endtask

	task automatic test_random_traffic();
		logic [15:0] w, h, thr, scale;
		for (int ph = 0; ph < 12; ph++) begin
			w     = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
			h     = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
			thr   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
			scale = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 13107));
			apply_config(w, h, thr, scale);
			allow_gaps = (ph % 4) != 3;
			repeat (150) send_prior(random_prior());
			allow_gaps = 1'b1;
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		start            <= 1'b0;
		cfg_valid        <= 1'b0;
		cfg_index        <= CFG_IMAGE_WIDTH;
		cfg_data         <= '0;
		prior_center     <= '0;
		prior_size       <= '0;
		corner_a_dx      <= '0;
		corner_a_dy      <= '0;
		corner_b_dx      <= '0;
		corner_b_dy      <= '0;
		corner_c_dx      <= '0;
		corner_c_dy      <= '0;
		corner_d_dx      <= '0;
		corner_d_dy      <= '0;
		plate_confidence <= '0;
		overlap_quality  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_config_extremes();
		test_random_traffic();
		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[plate_corner_decode.f]
+incdir+rtl/core
rtl/core/pcd_pkg.sv
rtl/core/pcd_coord_lane.sv
rtl/core/pcd_score.sv
rtl/core/plate_corner_decode.sv
rtl/core/pcd_checker.sv
tb/sv/testbench.sv
